>>> rtl/llf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llf_pkg: shared types and constants for the detail/edge remap block
// Fixed-point widths, register codes, the log2/exp2 mantissa tables and the
// structs that travel between the pipeline sections.
// ----------------------------------------------------------------------------
package llf_pkg;

	localparam int CH_W    = 16;  // channel word, signed Q2.14
	localparam int ABS_W   = 16;  // absolute channel difference
	localparam int SQ_W    = 32;  // one squared difference
	localparam int RAD_W   = 40;  // radicand in Q32 plus headroom for the trial value
	localparam int MAG_W   = 19;  // magnitude in Q16
	localparam int F_W     = 16;  // mag / sigma in Q0.16
	localparam int LEN_W   = 24;  // new length in Q16
	localparam int NUM_W   = 41;  // |delta| * length + mag / 2
	localparam int QUO_W   = 23;  // per-channel offset
	localparam int CFG_W   = 16;
	localparam int IDX_W   = 2;

	localparam logic [IDX_W-1:0] REG_SIGMA = 2'd0;
	localparam logic [IDX_W-1:0] REG_ALPHA = 2'd1;
	localparam logic [IDX_W-1:0] REG_BETA  = 2'd2;

	localparam logic [CFG_W-1:0] SIGMA_RST = 16'd13107;
	localparam logic [CFG_W-1:0] ALPHA_RST = 16'd2048;
	localparam logic [CFG_W-1:0] BETA_RST  = 16'd4096;
	localparam logic [CFG_W-1:0] ALPHA_ONE = 16'd4096;

	// Noise blend window: u = clamp(mag - 655, 0, 656), x = u * 4096 / 41.
	localparam logic [MAG_W-1:0] NOISE_LO   = 19'd655;
	localparam logic [MAG_W-1:0] NOISE_SPAN = 19'd656;
	localparam logic [21:0]      NOISE_DIV  = 22'd41;
	localparam logic [26:0]      RECIP_41   = 27'd104755299;  // floor(2^32 / 41)

	localparam logic [17:0] EXP2_TOP = 18'd131072;

	localparam int MAG_STAGES   = 3 + MAG_W;
	localparam int GAIN_STAGES  = F_W + 7;
	localparam int SCALE_STAGES = QUO_W + 2;

	typedef struct packed {
		logic [CFG_W-1:0] sigma;
		logic [CFG_W-1:0] alpha;
		logic [CFG_W-1:0] beta;
	} cfg_t;

	// What each pixel carries alongside its magnitude and length.
	typedef struct packed {
		logic [2:0][CH_W-1:0]  refc;
		logic [2:0][ABS_W-1:0] absd;
		logic [2:0]            neg;
	} side_t;

	// log2(1 + i/16) in Q16
	function automatic logic [16:0] log2_lut(input logic [4:0] i);
		case (i)
			5'd0:  return 17'd0;
			5'd1:  return 17'd5732;
			5'd2:  return 17'd11136;
			5'd3:  return 17'd16248;
			5'd4:  return 17'd21098;
			5'd5:  return 17'd25711;
			5'd6:  return 17'd30109;
			5'd7:  return 17'd34312;
			5'd8:  return 17'd38336;
			5'd9:  return 17'd42196;
			5'd10: return 17'd45904;
			5'd11: return 17'd49473;
			5'd12: return 17'd52911;
			5'd13: return 17'd56229;
			5'd14: return 17'd59434;
			5'd15: return 17'd62534;
			5'd16: return 17'd65536;
			default: return 17'd0;
		endcase
	endfunction

	// 2^(i/16) in Q16
	function automatic logic [17:0] exp2_lut(input logic [4:0] i);
		case (i)
			5'd0:  return 18'd65536;
			5'd1:  return 18'd68438;
			5'd2:  return 18'd71468;
			5'd3:  return 18'd74632;
			5'd4:  return 18'd77937;
			5'd5:  return 18'd81386;
			5'd6:  return 18'd84990;
			5'd7:  return 18'd88753;
			5'd8:  return 18'd92682;
			5'd9:  return 18'd96785;
			5'd10: return 18'd101070;
			5'd11: return 18'd105545;
			5'd12: return 18'd110218;
			5'd13: return 18'd115098;
			5'd14: return 18'd120194;
			5'd15: return 18'd125515;
			5'd16: return 18'd131072;
			default: return 18'd0;
		endcase
	endfunction

endpackage

>>> rtl/llf_mag.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llf_mag: difference and magnitude pipeline
// Forms the per-channel differences, squares and sums them, then takes the
// integer square root one result bit per stage.
// ----------------------------------------------------------------------------
module llf_mag import llf_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   in_vld,
	input  logic signed [CH_W-1:0] pix_r,
	input  logic signed [CH_W-1:0] pix_g,
	input  logic signed [CH_W-1:0] pix_b,
	input  logic signed [CH_W-1:0] ref_r,
	input  logic signed [CH_W-1:0] ref_g,
	input  logic signed [CH_W-1:0] ref_b,
	output logic                   vld,
	output side_t                  side,
	output logic [MAG_W-1:0]       mag
);

	logic [MAG_STAGES-1:0] vld_s;

	logic signed [CH_W:0] dlt [3];
	logic signed [CH_W:0] pix_x [3];
	logic signed [CH_W:0] ref_x [3];
	logic [CH_W:0]        dabs [3];

	side_t            side_s1, side_s2, side_s3;
	logic [SQ_W-1:0]  sq_s2 [3];
	logic [RAD_W-1:0] rad_s3;

	logic [RAD_W-1:0] rem_s  [MAG_W];
	logic [MAG_W-1:0] root_s [MAG_W];
	side_t            rside_s [MAG_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[MAG_STAGES-2:0], in_vld};
		end
	end

	always_comb begin
		pix_x[0] = (CH_W+1)'(pix_r);
		pix_x[1] = (CH_W+1)'(pix_g);
		pix_x[2] = (CH_W+1)'(pix_b);
		ref_x[0] = (CH_W+1)'(ref_r);
		ref_x[1] = (CH_W+1)'(ref_g);
		ref_x[2] = (CH_W+1)'(ref_b);
		for (int c = 0; c < 3; c++) begin
			dlt[c]  = pix_x[c] - ref_x[c];
			dabs[c] = dlt[c][CH_W] ? (CH_W+1)'(-dlt[c]) : (CH_W+1)'(dlt[c]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				side_s1.refc[c] <= ref_x[c][CH_W-1:0];
				side_s1.absd[c] <= dabs[c][ABS_W-1:0];
				side_s1.neg[c]  <= dlt[c][CH_W];
				sq_s2[c]        <= SQ_W'(side_s1.absd[c]) * SQ_W'(side_s1.absd[c]);
			end
			side_s2 <= side_s1;
			side_s3 <= side_s2;
			// Sum of squares is Q28; the root wants Q32.
			rad_s3  <= (RAD_W'(sq_s2[0]) + RAD_W'(sq_s2[1]) + RAD_W'(sq_s2[2])) << 4;
		end
	end

	for (genvar i = 0; i < MAG_W; i++) begin : g_root
		localparam int B = MAG_W - 1 - i;
		logic [RAD_W-1:0] rem_in;
		logic [MAG_W-1:0] root_in;
		side_t            side_in;
		logic [RAD_W-1:0] trial;

		if (i == 0) begin : g_first
			assign rem_in  = rad_s3;
			assign root_in = '0;
			assign side_in = side_s3;
		end else begin : g_next
			assign rem_in  = rem_s[i-1];
			assign root_in = root_s[i-1];
			assign side_in = rside_s[i-1];
		end

		assign trial = ((RAD_W'(root_in) << 1) | (RAD_W'(1) << B)) << B;

		always_ff @(posedge clk) begin
			if (en) begin
				if (rem_in >= trial) begin
					rem_s[i]  <= rem_in - trial;
					root_s[i] <= root_in | (MAG_W'(1) << B);
				end else begin
					rem_s[i]  <= rem_in;
					root_s[i] <= root_in;
				end
				rside_s[i] <= side_in;
			end
		end
	end

	assign vld  = vld_s[MAG_STAGES-1];
	assign side = rside_s[MAG_W-1];
	assign mag  = root_s[MAG_W-1];

endmodule

>>> rtl/llf_gain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llf_gain: new length from the magnitude
// Long division for mag / sigma, then log2, exponent scaling, exp2, the
// noise blend and the detail or edge length rule.
// ----------------------------------------------------------------------------
module llf_gain import llf_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  cfg_t             cfg,
	input  logic             in_vld,
	input  side_t            in_side,
	input  logic [MAG_W-1:0] in_mag,
	output logic             vld,
	output side_t            side,
	output logic [MAG_W-1:0] mag,
	output logic [LEN_W-1:0] len
);

	logic [GAIN_STAGES-1:0] vld_s;

	logic [F_W-1:0]   drem_s [F_W];
	logic [F_W-1:0]   fq_s   [F_W];
	logic [MAG_W-1:0] dmag_s [F_W];
	side_t            dside_s [F_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[GAIN_STAGES-2:0], in_vld};
		end
	end

	// One quotient bit a stage; only meaningful when mag < sigma.
	for (genvar i = 0; i < F_W; i++) begin : g_div
		logic [F_W-1:0]   rem_in;
		logic [F_W-1:0]   q_in;
		logic [MAG_W-1:0] mag_in;
		side_t            side_in;
		logic [F_W:0]     r2;
		logic             ge;

		if (i == 0) begin : g_first
			assign rem_in  = in_mag[F_W-1:0];
			assign q_in    = '0;
			assign mag_in  = in_mag;
			assign side_in = in_side;
		end else begin : g_next
			assign rem_in  = drem_s[i-1];
			assign q_in    = fq_s[i-1];
			assign mag_in  = dmag_s[i-1];
			assign side_in = dside_s[i-1];
		end

		assign r2 = {rem_in, 1'b0};
		assign ge = r2 >= (F_W+1)'(cfg.sigma);

		always_ff @(posedge clk) begin
			if (en) begin
				drem_s[i]  <= ge ? F_W'(r2 - (F_W+1)'(cfg.sigma)) : r2[F_W-1:0];
				fq_s[i]    <= {q_in[F_W-2:0], ge};
				dmag_s[i]  <= mag_in;
				dside_s[i] <= side_in;
			end
		end
	end

	// ---- stage 17: normalise f, start the blend reciprocal ----
	logic [F_W-1:0]   f_in;
	logic [MAG_W-1:0] mag_in;
	logic [3:0]       lead;
	logic [F_W-1:0]   nrm;
	logic [MAG_W-1:0] u;
	logic [21:0]      nb;

	logic [3:0]       lidx_s17, lead_s17;
	logic [10:0]      lfr_s17;
	logic [F_W-1:0]   f_s17;
	logic [21:0]      nb_s17;
	logic [48:0]      bprod_s17;
	logic [MAG_W-1:0] mag_s17;
	side_t            side_s17;

	assign f_in   = fq_s[F_W-1];
	assign mag_in = dmag_s[F_W-1];

	always_comb begin
		lead = '0;
		for (int b = 0; b < F_W; b++) begin
			if (f_in[b]) lead = 4'(b);
		end
		nrm = F_W'(f_in << (4'd15 - lead));
		u   = (mag_in > NOISE_LO) ? mag_in - NOISE_LO : '0;
		if (u > NOISE_SPAN) u = NOISE_SPAN;
		nb  = {u[9:0], 12'b0};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lidx_s17  <= nrm[14:11];
			lfr_s17   <= nrm[10:0];
			lead_s17  <= lead;
			f_s17     <= f_in;
			nb_s17    <= nb;
			bprod_s17 <= 49'(nb) * 49'(RECIP_41);
			mag_s17   <= mag_in;
			side_s17  <= dside_s[F_W-1];
		end
	end

	// ---- stage 18: -log2(f), blend abscissa ----
	logic [16:0] llo, lhi, ldif, lg;
	logic [27:0] lip;
	logic [16:0] q0;
	logic [21:0] rnb;
	logic [20:0] nl;

	logic [20:0]      nl_s18;
	logic [16:0]      x_s18;
	logic [F_W-1:0]   f_s18;
	logic [MAG_W-1:0] mag_s18;
	side_t            side_s18;

	always_comb begin
		llo  = log2_lut({1'b0, lidx_s17});
		lhi  = log2_lut({1'b0, lidx_s17} + 5'd1);
		ldif = lhi - llo;
		lip  = 28'(ldif) * 28'(lfr_s17);
		lg   = llo + 17'(lip >> 11);
		nl   = {5'd16 - {1'b0, lead_s17}, 16'b0} - 21'(lg);
		q0   = bprod_s17[48:32];
		rnb  = nb_s17 - 22'(23'(q0) * 23'(NOISE_DIV));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nl_s18   <= nl;
			x_s18    <= q0 + 17'(rnb >= NOISE_DIV);
			f_s18    <= f_s17;
			mag_s18  <= mag_s17;
			side_s18 <= side_s17;
		end
	end

	// ---- stage 19: exponent product, x squared ----
	logic [36:0]      ep_s19;
	logic [33:0]      xx_s19;
	logic [16:0]      x_s19;
	logic [F_W-1:0]   f_s19;
	logic [MAG_W-1:0] mag_s19;
	side_t            side_s19;

	always_ff @(posedge clk) begin
		if (en) begin
			ep_s19   <= 37'(cfg.alpha) * 37'(nl_s18);
			xx_s19   <= 34'(x_s18) * 34'(x_s18);
			x_s19    <= x_s18;
			f_s19    <= f_s18;
			mag_s19  <= mag_s18;
			side_s19 <= side_s18;
		end
	end

	// ---- stage 20: split the exponent, finish the smoothstep ----
	logic [37:0] esum;
	logic [24:0] e;
	logic [16:0] t;
	logic [17:0] t3;
	logic [51:0] bmul;

	logic [8:0]       k_s20;
	logic [4:0]       eidx_s20;
	logic [11:0]      efr_s20;
	logic [16:0]      blend_s20;
	logic [F_W-1:0]   f_s20;
	logic [MAG_W-1:0] mag_s20;
	side_t            side_s20;

	always_comb begin
		esum = 38'(ep_s19) + 38'd2048;
		e    = 25'(esum >> 12);
		t    = 17'd65536 - {1'b0, e[15:0]};
		t3   = 18'd196608 - {x_s19, 1'b0};
		bmul = 52'(xx_s19) * 52'(t3);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			k_s20     <= e[24:16];
			eidx_s20  <= t[16:12];
			efr_s20   <= t[11:0];
			blend_s20 <= 17'(bmul >> 32);
			f_s20     <= f_s19;
			mag_s20   <= mag_s19;
			side_s20  <= side_s19;
		end
	end

	// ---- stage 21: 2^-E ----
	logic [17:0] elo, ehi, edif, x2;
	logic [29:0] eip;
	logic [5:0]  esh;
	logic [16:0] pw;

	logic [16:0]      pow_s21;
	logic [16:0]      blend_s21;
	logic [F_W-1:0]   f_s21;
	logic [MAG_W-1:0] mag_s21;
	side_t            side_s21;

	always_comb begin
		elo  = exp2_lut(eidx_s20);
		ehi  = exp2_lut(eidx_s20 + 5'd1);
		edif = ehi - elo;
		eip  = 30'(edif) * 30'(efr_s20);
		x2   = eidx_s20[4] ? EXP2_TOP : elo + 18'(eip >> 12);
		esh  = 6'(k_s20[4:0]) + 6'd1;
		pw   = (k_s20 >= 9'd31) ? '0 : 17'(x2 >> esh);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pow_s21   <= pw;
			blend_s21 <= blend_s20;
			f_s21     <= f_s20;
			mag_s21   <= mag_s20;
			side_s21  <= side_s20;
		end
	end

	// ---- stage 22: blended power, edge product ----
	logic [34:0] p1, p2, ps;

	logic [16:0]      poly_s22;
	logic [34:0]      edp_s22;
	logic [MAG_W-1:0] mag_s22;
	side_t            side_s22;

	always_comb begin
		p1 = 35'(blend_s21) * 35'(pow_s21);
		p2 = 35'(17'd65536 - blend_s21) * 35'(f_s21);
		ps = p1 + p2 + 35'd32768;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			poly_s22 <= (cfg.alpha < ALPHA_ONE) ? 17'(ps >> 16) : pow_s21;
			edp_s22  <= 35'(mag_s21 - MAG_W'(cfg.sigma)) * 35'(cfg.beta);
			mag_s22  <= mag_s21;
			side_s22 <= side_s21;
		end
	end

	// ---- stage 23: length ----
	logic [33:0] dl;
	logic [35:0] es;

	logic [LEN_W-1:0] len_s23;
	logic [MAG_W-1:0] mag_s23;
	side_t            side_s23;

	always_comb begin
		dl = 34'(cfg.sigma) * 34'(poly_s22) + 34'd32768;
		es = 36'(edp_s22) + 36'd2048;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (mag_s22 < MAG_W'(cfg.sigma)) begin
				len_s23 <= LEN_W'(dl >> 16);
			end else begin
				len_s23 <= LEN_W'(es >> 12) + LEN_W'(cfg.sigma);
			end
			mag_s23  <= mag_s22;
			side_s23 <= side_s22;
		end
	end

	assign vld  = vld_s[GAIN_STAGES-1];
	assign side = side_s23;
	assign mag  = mag_s23;
	assign len  = len_s23;

endmodule

>>> rtl/llf_scale.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llf_scale: per-channel rescale and saturation
// Divides |delta| * length by the magnitude with rounding, one quotient bit
// a stage for all three channels, then offsets the reference and saturates.
// ----------------------------------------------------------------------------
module llf_scale import llf_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_vld,
	input  side_t                 in_side,
	input  logic [MAG_W-1:0]      in_mag,
	input  logic [LEN_W-1:0]      in_len,
	output logic                  vld,
	output logic [2:0][CH_W-1:0]  res
);

	logic [SCALE_STAGES-1:0] vld_s;

	logic [NUM_W-1:0] num_s1 [3];
	logic [MAG_W-1:0] mag_s1;
	side_t            side_s1;

	logic [MAG_W-1:0] rem_s  [QUO_W][3];
	logic [QUO_W-1:0] quo_s  [QUO_W][3];
	logic [QUO_W-1:0] nlo_s  [QUO_W][3];
	logic [MAG_W-1:0] dmag_s [QUO_W];
	side_t            dside_s [QUO_W];

	logic [2:0][CH_W-1:0] res_s25;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[SCALE_STAGES-2:0], in_vld};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				num_s1[c] <= NUM_W'(NUM_W'(in_side.absd[c]) * NUM_W'(in_len))
				           + NUM_W'(in_mag >> 1);
			end
			mag_s1  <= in_mag;
			side_s1 <= in_side;
		end
	end

	// The quotient fits in QUO_W bits, so the top of the numerator is already
	// below the magnitude and can seed the remainder.
	for (genvar i = 0; i < QUO_W; i++) begin : g_div
		localparam int B = QUO_W - 1 - i;
		logic [MAG_W-1:0] rem_in [3];
		logic [QUO_W-1:0] q_in   [3];
		logic [QUO_W-1:0] n_in   [3];
		logic [MAG_W-1:0] mag_in;
		side_t            side_in;
		logic [MAG_W:0]   r2     [3];
		logic             ge     [3];

		if (i == 0) begin : g_first
			for (genvar c = 0; c < 3; c++) begin : g_ch
				assign rem_in[c] = MAG_W'(num_s1[c][NUM_W-1:QUO_W]);
				assign q_in[c]   = '0;
				assign n_in[c]   = num_s1[c][QUO_W-1:0];
			end
			assign mag_in  = mag_s1;
			assign side_in = side_s1;
		end else begin : g_next
			for (genvar c = 0; c < 3; c++) begin : g_ch
				assign rem_in[c] = rem_s[i-1][c];
				assign q_in[c]   = quo_s[i-1][c];
				assign n_in[c]   = nlo_s[i-1][c];
			end
			assign mag_in  = dmag_s[i-1];
			assign side_in = dside_s[i-1];
		end

		for (genvar c = 0; c < 3; c++) begin : g_cmp
			assign r2[c] = {rem_in[c], n_in[c][B]};
			assign ge[c] = r2[c] >= (MAG_W+1)'(mag_in);
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int c = 0; c < 3; c++) begin
					rem_s[i][c] <= ge[c] ? MAG_W'(r2[c] - (MAG_W+1)'(mag_in))
					                     : MAG_W'(r2[c]);
					quo_s[i][c] <= {q_in[c][QUO_W-2:0], ge[c]};
					nlo_s[i][c] <= n_in[c];
				end
				dmag_s[i]  <= mag_in;
				dside_s[i] <= side_in;
			end
		end
	end

	localparam logic signed [CH_W+8:0] SAT_HI = (CH_W+9)'(32767);
	localparam logic signed [CH_W+8:0] SAT_LO = -(CH_W+9)'(32768);

	logic signed [CH_W+8:0] sr [3];
	logic signed [CH_W+8:0] qv [3];
	logic signed [CH_W+8:0] o  [3];
	logic [2:0][CH_W-1:0]   sat;
	side_t                  side_l;

	assign side_l = dside_s[QUO_W-1];

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			sr[c] = (CH_W+9)'($signed(side_l.refc[c]));
			qv[c] = $signed({2'b00, quo_s[QUO_W-1][c]});
			o[c]  = side_l.neg[c] ? sr[c] - qv[c] : sr[c] + qv[c];
			if (dmag_s[QUO_W-1] == '0) begin
				sat[c] = side_l.refc[c];
			end else if (o[c] > SAT_HI) begin
				sat[c] = SAT_HI[CH_W-1:0];
			end else if (o[c] < SAT_LO) begin
				sat[c] = SAT_LO[CH_W-1:0];
			end else begin
				sat[c] = o[c][CH_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s25 <= sat;
		end
	end

	assign vld = vld_s[SCALE_STAGES-1];
	assign res = res_s25;

endmodule

>>> rtl/llf_detail_edge_remap.sv
`timescale 1ns / 1ps
// Throughput: one word per cycle; the pipeline moves as a whole and halts
// only while a finished result is held by out_stall.
// Rate is set by the bit-per-stage square root and dividers, all fully pipelined.
// Reset clears every valid bit and loads sigma, alpha and beta with defaults.
// ----------------------------------------------------------------------------
// llf_detail_edge_remap: local Laplacian detail/edge remap of one RGB pixel
// Top level: configuration registers, pipeline advance and the three sections.
// ----------------------------------------------------------------------------
module llf_detail_edge_remap import llf_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [IDX_W-1:0]       cfg_idx,
	input  logic [CFG_W-1:0]       cfg_data,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic signed [CH_W-1:0] pix_r,
	input  logic signed [CH_W-1:0] pix_g,
	input  logic signed [CH_W-1:0] pix_b,
	input  logic signed [CH_W-1:0] ref_r,
	input  logic signed [CH_W-1:0] ref_g,
	input  logic signed [CH_W-1:0] ref_b,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic signed [CH_W-1:0] out_r,
	output logic signed [CH_W-1:0] out_g,
	output logic signed [CH_W-1:0] out_b
);

	cfg_t cfg_q;
	logic en;

	logic             m_vld;
	side_t            m_side;
	logic [MAG_W-1:0] m_mag;

	logic             g_vld;
	side_t            g_side;
	logic [MAG_W-1:0] g_mag;
	logic [LEN_W-1:0] g_len;

	logic                 s_vld;
	logic [2:0][CH_W-1:0] s_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sigma <= SIGMA_RST;
			cfg_q.alpha <= ALPHA_RST;
			cfg_q.beta  <= BETA_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_SIGMA: cfg_q.sigma <= cfg_data;
				REG_ALPHA: cfg_q.alpha <= cfg_data;
				REG_BETA:  cfg_q.beta  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Everything advances unless the output word is being held.
	assign en       = !(s_vld && out_stall);
	assign in_stall = !en;

	llf_mag u_mag (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_vld (in_valid),
		.pix_r  (pix_r),
		.pix_g  (pix_g),
		.pix_b  (pix_b),
		.ref_r  (ref_r),
		.ref_g  (ref_g),
		.ref_b  (ref_b),
		.vld    (m_vld),
		.side   (m_side),
		.mag    (m_mag)
	);

	llf_gain u_gain (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.cfg     (cfg_q),
		.in_vld  (m_vld),
		.in_side (m_side),
		.in_mag  (m_mag),
		.vld     (g_vld),
		.side    (g_side),
		.mag     (g_mag),
		.len     (g_len)
	);

	llf_scale u_scale (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (g_vld),
		.in_side (g_side),
		.in_mag  (g_mag),
		.in_len  (g_len),
		.vld     (s_vld),
		.res     (s_res)
	);

	assign out_valid = s_vld;
	assign out_r     = $signed(s_res[0]);
	assign out_g     = $signed(s_res[1]);
	assign out_b     = $signed(s_res[2]);

endmodule

>>> rtl/llf_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llf_chk: port-level checks for the remap block
// Ties input back-pressure to a held output word and checks the held word.
// ----------------------------------------------------------------------------
module llf_chk import llf_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_stall,
	input logic                   out_valid,
	input logic                   out_stall,
	input logic signed [CH_W-1:0] out_r,
	input logic signed [CH_W-1:0] out_g,
	input logic signed [CH_W-1:0] out_b
);

	// The input is only pushed back while a result word waits.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without a held output word");

	// A held result word must halt the whole pipeline.
	a_stall_needed: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |-> in_stall)
		else $error("input taken while the output word is held");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid)
		else $error("held output word dropped");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> ($stable(out_r) && $stable(out_g) && $stable(out_b)))
		else $error("held output word changed");

endmodule

bind llf_detail_edge_remap llf_chk u_llf_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_r     (out_r),
	.out_g     (out_g),
	.out_b     (out_b)
);
